// ===== hw/rtl/gfas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the grid forward advection splat block.
package gfas_pkg;

	localparam int ACC_W  = 24;
	localparam int IN_W   = 16;
	localparam int CELL_W = 6;
	localparam int CFG_W  = 6;
	localparam int SUM_W  = ACC_W + 2;

	localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(8388608);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_SPLAT = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_GRID = 1'b1;

	localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(62);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_GEO,
		ST_CHECK,
		ST_ADDR,
		ST_READ,
		ST_WRITE,
		ST_RADDR,
		ST_RREAD,
		ST_RESULT
	} gfas_state_t;

	typedef struct packed {
		logic       init_wr;
		logic       load;
		logic       clr_wr;
		logic       addr_en;
		logic       rsel;
		logic       rd_en;
		logic       acc_wr;
		logic [1:0] corner;
	} gfas_ctl_t;

	typedef struct packed {
		logic init_last;
		logic clr_last;
		logic splat_ok;
	} gfas_sts_t;

endpackage

// ===== hw/rtl/gfas_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for reset sweep, clear sweep, splat corners and reads.
module gfas_ctrl import gfas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	output logic       busy,
	output logic       done,
	output gfas_ctl_t  ctl,
	input  gfas_sts_t  sts
);

	gfas_state_t state_q, state_d;
	logic [1:0]  corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				corner_q <= '0;
			end else if (state_q == ST_WRITE) begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_SPLAT: state_d = ST_GEO;
						CMD_READ:  state_d = ST_RADDR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_GEO:   state_d = ST_CHECK;
			ST_CHECK: state_d = sts.splat_ok ? ST_ADDR : ST_IDLE;
			ST_ADDR:  state_d = ST_READ;
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: state_d = (corner_q == 2'd3) ? ST_IDLE : ST_ADDR;
			ST_RADDR: state_d = ST_RREAD;
			ST_RREAD: state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.corner = corner_q;
		busy       = 1'b1;
		done       = 1'b0;
		case (state_q)
			ST_INIT:   ctl.init_wr = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_CLEAR:  ctl.clr_wr = 1'b1;
			ST_ADDR:   ctl.addr_en = 1'b1;
			ST_READ:   ctl.rd_en = 1'b1;
			ST_WRITE:  ctl.acc_wr = 1'b1;
			ST_RADDR: begin
				ctl.addr_en = 1'b1;
				ctl.rsel    = 1'b1;
			end
			ST_RREAD:  ctl.rd_en = 1'b1;
			ST_RESULT: done = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

endmodule

// ===== hw/rtl/gfas_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config, splat geometry, weight multipliers and accumulator stores.
module gfas_dp import gfas_pkg::*; #(
	parameter int MAX_INTERIOR = 62,
	parameter int FRAC_BITS    = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gfas_ctl_t                ctl,
	output gfas_sts_t                sts,
	input  logic                     cfg_valid,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic [CELL_W-1:0]        cell_x,
	input  logic [CELL_W-1:0]        cell_y,
	input  logic signed [IN_W-1:0]   vel_x,
	input  logic signed [IN_W-1:0]   vel_y,
	input  logic signed [IN_W-1:0]   quantity,
	output logic signed [ACC_W-1:0]  chan_a,
	output logic signed [ACC_W-1:0]  chan_b
);

	localparam int SIDE_MAX = MAX_INTERIOR + 2;
	localparam int DEPTH    = SIDE_MAX * SIDE_MAX;
	localparam int AW       = $clog2(DEPTH);
	localparam int SW       = $clog2(SIDE_MAX + 1);
	localparam int TW       = 24;
	localparam int F        = FRAC_BITS;
	localparam int WW       = F + 1;
	localparam int P1W      = IN_W + WW + 1;
	localparam int P2W      = P1W + WW + 1;

	localparam logic [WW-1:0]  ONE  = WW'(1) << F;
	localparam logic [P2W-1:0] HALF = P2W'(1) << (2 * F - 1);

	function automatic logic [AW-1:0] cell_addr(logic [SW-1:0] s, logic [SW-1:0] x,
		logic [SW-1:0] y);
		logic [2*SW:0] sum;
		sum = (2*SW+1)'(s) * (2*SW+1)'(y) + (2*SW+1)'(x);
		return sum[AW-1:0];
	endfunction

	logic                     mode_q;
	logic [CFG_W-1:0]         grid_q;
	logic [CELL_W-1:0]        x_q, y_q;
	logic signed [IN_W-1:0]   vx_q, vy_q, qty_q;

	logic [TW-1:0]            n_u, side_u, xr_u, yr_u;
	logic signed [TW-1:0]     side_s, tx, ty, fx, fy, cx, cy;
	logic                     geo_ok;

	logic [SW-1:0]            fx_q, fy_q, cx_q, cy_q;
	logic [F-1:0]             dx_q, dy_q;
	logic                     ok_q, rok_q;

	logic [SW-1:0]            i_q, j_q;
	logic [AW-1:0]            idx_q, addr_q, clr_addr, wa;

	logic                     x_hi, y_hi;
	logic [SW-1:0]            xs, ys;
	logic [WW-1:0]            wxs, wys, wy_s1;
	logic signed [IN_W-1:0]   amt_a;
	logic signed [P1W-1:0]    p1a_s1, p1b_s1;
	logic signed [P2W-1:0]    p2a_s2, p2b_s2, ra, rb;
	logic signed [SUM_W-1:0]  suma, sumb;
	logic signed [ACC_W-1:0]  sata, satb, wd_a, wd_b, rd_a_q, rd_b_q;
	logic                     we_a, we_b;

	logic signed [ACC_W-1:0]  mem_a [DEPTH];
	logic signed [ACC_W-1:0]  mem_b [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			grid_q <= GRID_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_GRID: grid_q <= cfg_data;
				default:  mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q   <= cell_x;
			y_q   <= cell_y;
			vx_q  <= vel_x;
			vy_q  <= vel_y;
			qty_q <= quantity;
		end
	end

	always_comb begin
		n_u = TW'(grid_q);
		if (grid_q == '0) begin
			n_u = TW'(1);
		end else if (n_u > TW'(MAX_INTERIOR)) begin
			n_u = TW'(MAX_INTERIOR);
		end
		side_u = n_u + TW'(2);
		side_s = $signed(side_u);
		xr_u   = TW'(x_q);
		yr_u   = TW'(y_q);
		tx     = $signed(xr_u << F) + TW'(vx_q);
		ty     = $signed(yr_u << F) + TW'(vy_q);
		fx     = tx >>> F;
		fy     = ty >>> F;
		cx     = fx + TW'(tx[F-1:0] != '0);
		cy     = fy + TW'(ty[F-1:0] != '0);
		geo_ok = (xr_u >= TW'(1)) && (xr_u <= n_u) && (yr_u >= TW'(1)) && (yr_u <= n_u)
			&& (fx >= 0) && (fy >= 0) && (cx < side_s) && (cy < side_s);
	end

	always_ff @(posedge clk) begin
		fx_q  <= fx[SW-1:0];
		fy_q  <= fy[SW-1:0];
		cx_q  <= cx[SW-1:0];
		cy_q  <= cy[SW-1:0];
		dx_q  <= tx[F-1:0];
		dy_q  <= ty[F-1:0];
		ok_q  <= geo_ok;
		rok_q <= (xr_u < side_u) && (yr_u < side_u);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			i_q   <= SW'(1);
			j_q   <= SW'(1);
		end else begin
			if (ctl.init_wr) idx_q <= idx_q + AW'(1);
			if (ctl.load) begin
				i_q <= SW'(1);
				j_q <= SW'(1);
			end else if (ctl.clr_wr) begin
				if (i_q == n_u[SW-1:0]) begin
					i_q <= SW'(1);
					j_q <= j_q + SW'(1);
				end else begin
					i_q <= i_q + SW'(1);
				end
			end
		end
	end

	assign sts.init_last = (idx_q == AW'(DEPTH - 1));
	assign sts.clr_last  = (i_q == n_u[SW-1:0]) && (j_q == n_u[SW-1:0]);
	assign sts.splat_ok  = ok_q;

	assign x_hi  = ctl.corner[1];
	assign y_hi  = ctl.corner[1] ^ ctl.corner[0];
	assign xs    = ctl.rsel ? xr_u[SW-1:0] : (x_hi ? cx_q : fx_q);
	assign ys    = ctl.rsel ? yr_u[SW-1:0] : (y_hi ? cy_q : fy_q);
	assign wxs   = x_hi ? {1'b0, dx_q} : ONE - {1'b0, dx_q};
	assign wys   = y_hi ? {1'b0, dy_q} : ONE - {1'b0, dy_q};
	assign amt_a = mode_q ? vx_q : qty_q;

	assign clr_addr = cell_addr(side_u[SW-1:0], i_q, j_q);

	always_ff @(posedge clk) begin
		if (ctl.addr_en) addr_q <= cell_addr(side_u[SW-1:0], xs, ys);
		p1a_s1 <= P1W'(amt_a) * P1W'($signed({1'b0, wxs}));
		p1b_s1 <= P1W'(vy_q) * P1W'($signed({1'b0, wxs}));
		wy_s1  <= wys;
		p2a_s2 <= P2W'(p1a_s1) * P2W'($signed({1'b0, wy_s1}));
		p2b_s2 <= P2W'(p1b_s1) * P2W'($signed({1'b0, wy_s1}));
	end

	always_comb begin
		ra   = (p2a_s2 + $signed(HALF)) >>> (2 * F);
		rb   = (p2b_s2 + $signed(HALF)) >>> (2 * F);
		suma = SUM_W'(rd_a_q) + SUM_W'(ra);
		sumb = SUM_W'(rd_b_q) + SUM_W'(rb);
		if (suma > ACC_MAX)      sata = ACC_MAX[ACC_W-1:0];
		else if (suma < ACC_MIN) sata = ACC_MIN[ACC_W-1:0];
		else                     sata = suma[ACC_W-1:0];
		if (sumb > ACC_MAX)      satb = ACC_MAX[ACC_W-1:0];
		else if (sumb < ACC_MIN) satb = ACC_MIN[ACC_W-1:0];
		else                     satb = sumb[ACC_W-1:0];
	end

	assign we_a = ctl.init_wr | ctl.clr_wr | ctl.acc_wr;
	assign we_b = ctl.init_wr | (mode_q & (ctl.clr_wr | ctl.acc_wr));
	assign wa   = ctl.init_wr ? idx_q : (ctl.clr_wr ? clr_addr : addr_q);
	assign wd_a = ctl.acc_wr ? sata : '0;
	assign wd_b = ctl.acc_wr ? satb : '0;

	always_ff @(posedge clk) begin
		if (we_a) mem_a[wa] <= wd_a;
		if (ctl.rd_en) rd_a_q <= mem_a[addr_q];
	end

	always_ff @(posedge clk) begin
		if (we_b) mem_b[wa] <= wd_b;
		if (ctl.rd_en) rd_b_q <= mem_b[addr_q];
	end

	assign chan_a = rok_q ? rd_a_q : '0;
	assign chan_b = rok_q ? rd_b_q : '0;

endmodule

// ===== hw/rtl/grid_forward_advection_splat.sv =====
`timescale 1ns / 1ps
// Top level: forward advection by bilinear splatting into accumulator stores.
// Usage:
//   Command channel: an item is taken on a clock edge with start high and
//   busy low. cmd selects clear, splat or read; cmd 3 is taken and ignored.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 mode, 1 grid size)
//   and cfg_data; cfg_ready is always high. Write only while busy is low.
//   Result: a read returns chan_a/chan_b for one cycle with done high, in the
//   RESULT state after RADDR and RREAD. The receiver cannot stall.
// Sequence per item (one read and one write port per store, read-modify-write
//   per corner): splat: GEO and CHECK for geometry, then ADDR, READ, WRITE
//   for each of the 4 corners; dropped splat: ends after CHECK; read: RADDR,
//   RREAD, RESULT; clear: n*n interior cells, one interior cell per cycle.
// Reset: both stores are zeroed by a sweep over all (MAX_INTERIOR+2)^2 cells
//   (4096 at the default size); busy stays high until it ends. Config
//   writes are taken during the sweep.
module grid_forward_advection_splat import gfas_pkg::*; #(
	parameter int MAX_INTERIOR = 62,
	parameter int FRAC_BITS    = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               cmd,
	input  logic [CELL_W-1:0]        cell_x,
	input  logic [CELL_W-1:0]        cell_y,
	input  logic signed [IN_W-1:0]   vel_x,
	input  logic signed [IN_W-1:0]   vel_y,
	input  logic signed [IN_W-1:0]   quantity,
	output logic                     done,
	output logic signed [ACC_W-1:0]  chan_a,
	output logic signed [ACC_W-1:0]  chan_b,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	gfas_ctl_t ctl;
	gfas_sts_t sts;

	assign cfg_ready = 1'b1;

	gfas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	gfas_dp #(
		.MAX_INTERIOR (MAX_INTERIOR),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.quantity  (quantity),
		.chan_a    (chan_a),
		.chan_b    (chan_b)
	);

endmodule
